// File: rtl/video_bus_address_map_core_assert.svh
// assertion macros for the video bus address map checker
// expects clk_i and rst_ni in the scope of each use
`ifndef VIDEO_BUS_ADDRESS_MAP_CORE_ASSERT_SVH
`define VIDEO_BUS_ADDRESS_MAP_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define VBAM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("video bus address map assertion failed");

// next-cycle implication, disabled in reset
`define VBAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("video bus address map assertion failed");

`endif

// File: rtl/vbam_pkg.sv
// shared constants for the video bus address map
// no dependencies
package vbam_pkg;

  // command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;
  localparam logic [1:0] CMD_BAD   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ROM      = 2'd1;
  localparam logic [1:0] ST_UNMAPPED = 2'd2;

  // read data source codes
  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_ROM  = 2'd1;
  localparam logic [1:0] SRC_RAM  = 2'd2;
  localparam logic [1:0] SRC_PAL  = 2'd3;

  // address map
  localparam logic [15:0] ROM_LAST     = 16'h1FFF;
  localparam logic [15:0] RAM_FIRST    = 16'h2000;
  localparam logic [15:0] RAM_LAST     = 16'h2FFF;
  localparam logic [15:0] PAL_FIRST    = 16'h3F00;
  localparam logic [15:0] PAL_BG_LAST  = 16'h3F0F;
  localparam logic [15:0] PAL_SP_FIRST = 16'h3F10;
  localparam logic [15:0] PAL_SP_LAST  = 16'h3F1F;
  localparam logic [15:0] PAL_LAST     = 16'h3FFF;

  // storage sizes
  localparam int unsigned ROM_DEPTH = 8192;
  localparam int unsigned RAM_DEPTH = 4096;
  localparam int unsigned PAL_DEPTH = 16;

endpackage

// File: rtl/vbam_if.sv
// valid/ready channel interfaces for access items and result items
// no dependencies
interface vbam_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, command, address, write_data, input ready);
  modport sink   (input valid, command, address, write_data, output ready);
endinterface

interface vbam_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [1:0] status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

// File: rtl/video_bus_address_map_core.sv
// video bus address map: decode, pattern rom, name table ram, palettes
// depends on vbam_pkg, vbam_if and vbam_ram
// result: registered, valid in the cycle after the item is accepted
// throughput: one item per cycle while the result is not stalled; a held result blocks new items
// reset: clears the result valid flag and both palettes to zero
// pattern rom and name table ram hold no reset value until loaded or written
module video_bus_address_map_core (
  input  logic clk_i,
  input  logic rst_ni,
  vbam_in_if.sink    in_i,
  vbam_out_if.source out_o
);
  import vbam_pkg::*;

  logic        acc;
  logic [15:0] addr;
  logic        is_rom, is_ram, is_pal, is_pal_bg, is_pal_sp;
  logic [1:0]  status_d, status_q;
  logic [1:0]  src_d, src_q;
  logic        valid_q;
  logic        rom_en, rom_we, ram_en, ram_we, bg_we, sp_we;
  logic [3:0]  pal_idx;
  logic [7:0]  pal_d, pal_q;
  logic [7:0]  rom_rdata, ram_rdata;
  logic [7:0]  bg_q [PAL_DEPTH];
  logic [7:0]  sp_q [PAL_DEPTH];

  // handshake: take an item when the result register is free or drains
  assign in_i.ready = !valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign addr       = in_i.address;
  assign pal_idx    = addr[3:0];

  // address regions
  assign is_rom    = addr <= ROM_LAST;
  assign is_ram    = addr inside {[RAM_FIRST:RAM_LAST]};
  assign is_pal    = addr inside {[PAL_FIRST:PAL_LAST]};
  assign is_pal_bg = addr inside {[PAL_FIRST:PAL_BG_LAST]};
  assign is_pal_sp = addr inside {[PAL_SP_FIRST:PAL_SP_LAST]};

  // command decode
  always_comb begin
    status_d = ST_OK;
    src_d    = SRC_NONE;
    rom_en   = 1'b0;
    rom_we   = 1'b0;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    bg_we    = 1'b0;
    sp_we    = 1'b0;
    case (in_i.command)
      CMD_READ: begin
        if (is_rom) begin
          src_d  = SRC_ROM;
          rom_en = acc;
        end else if (is_ram) begin
          src_d  = SRC_RAM;
          ram_en = acc;
        end else if (is_pal) begin
          src_d = SRC_PAL;
        end else begin
          status_d = ST_UNMAPPED;
        end
      end
      CMD_WRITE: begin
        if (is_rom) begin
          status_d = ST_ROM;
        end else if (is_ram) begin
          ram_en = acc;
          ram_we = 1'b1;
        end else if (is_pal_bg) begin
          bg_we = acc;
        end else if (is_pal_sp) begin
          // sprite-half multiples of four land in the background table
          if (addr[1:0] == 2'b00) begin
            bg_we = acc;
          end else begin
            sp_we = acc;
          end
        end else begin
          status_d = ST_UNMAPPED;
        end
      end
      CMD_LOAD: begin
        if (is_rom) begin
          rom_en = acc;
          rom_we = 1'b1;
        end else begin
          status_d = ST_UNMAPPED;
        end
      end
      default: begin
        status_d = ST_UNMAPPED;
      end
    endcase
  end

  // palette read with 32-byte mirror and shared entry zero
  always_comb begin
    if (addr[1:0] == 2'b00) begin
      pal_d = bg_q[0];
    end else if (!addr[4]) begin
      pal_d = bg_q[pal_idx];
    end else begin
      pal_d = sp_q[pal_idx];
    end
  end

  // palette tables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PAL_DEPTH; i++) begin
        bg_q[i] <= 8'h00;
        sp_q[i] <= 8'h00;
      end
    end else begin
      if (bg_we) begin
        bg_q[pal_idx] <= in_i.write_data;
      end
      if (sp_we) begin
        sp_q[pal_idx] <= in_i.write_data;
      end
    end
  end

  // pattern rom
  vbam_ram #(
    .Width (8),
    .Depth (ROM_DEPTH)
  ) u_rom (
    .clk_i   (clk_i),
    .en_i    (rom_en),
    .we_i    (rom_we),
    .addr_i  (addr[12:0]),
    .wdata_i (in_i.write_data),
    .rdata_o (rom_rdata)
  );

  // name table ram
  vbam_ram #(
    .Width (8),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (addr[11:0]),
    .wdata_i (in_i.write_data),
    .rdata_o (ram_rdata)
  );

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (acc) begin
      status_q <= status_d;
      src_q    <= src_d;
      pal_q    <= pal_d;
    end
  end

  // result select
  always_comb begin
    case (src_q)
      SRC_ROM: out_o.read_data = rom_rdata;
      SRC_RAM: out_o.read_data = ram_rdata;
      SRC_PAL: out_o.read_data = pal_q;
      default: out_o.read_data = 8'h00;
    endcase
  end

  assign out_o.valid  = valid_q;
  assign out_o.status = status_q;

endmodule

// File: rtl/vbam_ram.sv
// generic single-port ram with registered read
// no dependencies
module vbam_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write, or read into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/vbam_checker.sv
// port-level checks for the video bus address map, with its bind
// depends on vbam_pkg and video_bus_address_map_core_assert.svh
`include "video_bus_address_map_core_assert.svh"

module vbam_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_command_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_read_data_i,
  input logic [1:0] out_status_i
);
  import vbam_pkg::*;

  logic in_acc;
  logic out_stall;
  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // every accepted item shows a result next cycle
  `VBAM_ASSERT_NEXT(a_result_follows, in_acc, out_valid_i)
  // an unknown command is reported as unmapped
  `VBAM_ASSERT_NEXT(a_bad_cmd, in_acc && in_command_i == CMD_BAD, out_status_i == ST_UNMAPPED)
  // errors carry zero data
  `VBAM_ASSERT_NOW(a_err_zero, out_valid_i && out_status_i != ST_OK, out_read_data_i == 8'h00)
  // a stalled result holds
  `VBAM_ASSERT_NEXT(a_hold, out_stall, out_valid_i && $stable({out_read_data_i, out_status_i}))

endmodule

bind video_bus_address_map_core vbam_checker u_vbam_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_command_i    (in_i.command),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_read_data_i (out_o.read_data),
  .out_status_i    (out_o.status)
);

// File: tb/tb_top.sv
// self-checking testbench for video_bus_address_map_core: directed table, then random accesses
// depends on vbam_pkg and the vbam_in_if / vbam_out_if channel interfaces from the rtl
// results are predicted per accepted item and checked in order on the result channel
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vbam_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned MAX_REPORTS  = 30;

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } access_result_t;

  // one directed access; typed_result marks rows whose result is written out here
  typedef struct packed {
    logic [1:0]     command;
    logic [15:0]    address;
    logic [7:0]     write_data;
    bit             typed_result;
    access_result_t result;
  } access_row_t;

  localparam int unsigned DIRECTED_ROWS = 25;

  logic clk_i = 1'b0;
  logic rst_ni;

  vbam_in_if  access_bus ();
  vbam_out_if result_bus ();

  video_bus_address_map_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (access_bus),
    .out_o  (result_bus)
  );

  always #2 clk_i = ~clk_i;

  // predicted memory contents
  logic [7:0] rom_image [ROM_DEPTH];
  logic [7:0] ram_image [RAM_DEPTH];
  logic [7:0] bg_image  [PAL_DEPTH];
  logic [7:0] sp_image  [PAL_DEPTH];

  // entries that hold a defined value once the items issued so far are done
  bit          rom_loaded  [ROM_DEPTH];
  bit          ram_written [RAM_DEPTH];
  logic [15:0] loaded_rom_addrs[$];
  logic [15:0] written_ram_addrs[$];

  access_result_t pending_results[$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned n_reads, n_writes, n_loads, n_errors, n_palette;
  bit          calm_stretch;
  bit          hold_off_req;

  access_row_t directed_rows [DIRECTED_ROWS] = '{
    '{CMD_READ,  16'h3F00, 8'h00, 1'b1, '{8'h00, ST_OK}},
    '{CMD_READ,  16'h3FFF, 8'hFF, 1'b1, '{8'h00, ST_OK}},
    '{CMD_WRITE, 16'h0000, 8'hAA, 1'b1, '{8'h00, ST_ROM}},
    '{CMD_WRITE, 16'h1FFF, 8'h55, 1'b1, '{8'h00, ST_ROM}},
    '{CMD_LOAD,  16'h0000, 8'hFF, 1'b1, '{8'h00, ST_OK}},
    '{CMD_LOAD,  16'h1FFF, 8'h00, 1'b1, '{8'h00, ST_OK}},
    '{CMD_READ,  16'h0000, 8'h00, 1'b0, '{8'h00, ST_OK}},
    '{CMD_READ,  16'h1FFF, 8'hFF, 1'b0, '{8'h00, ST_OK}},
    '{CMD_LOAD,  16'h2000, 8'h12, 1'b1, '{8'h00, ST_UNMAPPED}},
    '{CMD_WRITE, 16'h2000, 8'hA5, 1'b1, '{8'h00, ST_OK}},
    '{CMD_WRITE, 16'h2FFF, 8'h5A, 1'b1, '{8'h00, ST_OK}},
    '{CMD_READ,  16'h2000, 8'h00, 1'b0, '{8'h00, ST_OK}},
    '{CMD_READ,  16'h2FFF, 8'h00, 1'b0, '{8'h00, ST_OK}},
    '{CMD_READ,  16'h3000, 8'h00, 1'b1, '{8'h00, ST_UNMAPPED}},
    '{CMD_WRITE, 16'h3EFF, 8'h77, 1'b1, '{8'h00, ST_UNMAPPED}},
    '{CMD_READ,  16'hFFFF, 8'h00, 1'b1, '{8'h00, ST_UNMAPPED}},
    '{CMD_LOAD,  16'hFFFF, 8'h01, 1'b1, '{8'h00, ST_UNMAPPED}},
    '{CMD_BAD,   16'h2000, 8'hC3, 1'b1, '{8'h00, ST_UNMAPPED}},
    '{CMD_WRITE, 16'h3F01, 8'h11, 1'b1, '{8'h00, ST_OK}},
    '{CMD_WRITE, 16'h3F10, 8'h22, 1'b1, '{8'h00, ST_OK}},
    '{CMD_WRITE, 16'h3F1F, 8'h33, 1'b1, '{8'h00, ST_OK}},
    '{CMD_WRITE, 16'h3F20, 8'h44, 1'b1, '{8'h00, ST_UNMAPPED}},
    '{CMD_READ,  16'h3F10, 8'h00, 1'b0, '{8'h00, ST_OK}},
    '{CMD_READ,  16'h3FE1, 8'h00, 1'b0, '{8'h00, ST_OK}},
    '{CMD_READ,  16'h3F3F, 8'h00, 1'b0, '{8'h00, ST_OK}}
  };

  // decode one access against the predicted memories and update them
  function automatic access_result_t decode_access(input logic [1:0] cmd,
                                                   input logic [15:0] addr,
                                                   input logic [7:0] wdata);
    access_result_t res;
    res.read_data = 8'h00;
    res.status    = ST_OK;
    case (cmd)
      CMD_READ: begin
        n_reads++;
        if (addr <= ROM_LAST) begin
          res.read_data = rom_image[addr[12:0]];
        end else if (addr <= RAM_LAST) begin
          res.read_data = ram_image[addr[11:0]];
        end else if (addr < PAL_FIRST || addr > PAL_LAST) begin
          res.status = ST_UNMAPPED;
        end else begin
          // palette mirrors every 32 bytes; multiples of 4 all show background entry 0
          n_palette++;
          if (addr[1:0] == 2'b00) res.read_data = bg_image[0];
          else if (!addr[4])      res.read_data = bg_image[addr[3:0]];
          else                    res.read_data = sp_image[addr[3:0]];
        end
      end
      CMD_WRITE: begin
        n_writes++;
        if (addr <= ROM_LAST) begin
          res.status = ST_ROM;
        end else if (addr <= RAM_LAST) begin
          ram_image[addr[11:0]] = wdata;
        end else if (addr < PAL_FIRST) begin
          res.status = ST_UNMAPPED;
        end else if (addr <= PAL_BG_LAST) begin
          n_palette++;
          bg_image[addr[3:0]] = wdata;
        end else if (addr <= PAL_SP_LAST) begin
          // sprite-half multiples of 4 land in the background table
          n_palette++;
          if (addr[1:0] == 2'b00) bg_image[addr[3:0]] = wdata;
          else                    sp_image[addr[3:0]] = wdata;
        end else begin
          res.status = ST_UNMAPPED;
        end
      end
      CMD_LOAD: begin
        n_loads++;
        if (addr <= ROM_LAST) rom_image[addr[12:0]] = wdata;
        else                  res.status = ST_UNMAPPED;
      end
      default: begin
        res.status = ST_UNMAPPED;
      end
    endcase
    if (res.status != ST_OK) n_errors++;
    return res;
  endfunction

  // random idle decision shared by both sides
  function automatic bit take_break();
    return !calm_stretch && ($urandom_range(99) < 7);
  endfunction

  task automatic report_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch on %s, result %0d: got %h, want %h",
               $time, field, results_seen, got, want);
  endtask

  // record which rom / ram entries become defined once this item is done
  task automatic note_defined(input logic [1:0] cmd, input logic [15:0] addr);
    if (cmd == CMD_LOAD && addr <= ROM_LAST && !rom_loaded[addr[12:0]]) begin
      rom_loaded[addr[12:0]] = 1'b1;
      loaded_rom_addrs.push_back(addr);
    end
    if (cmd == CMD_WRITE && addr >= RAM_FIRST && addr <= RAM_LAST &&
        !ram_written[addr[11:0]]) begin
      ram_written[addr[11:0]] = 1'b1;
      written_ram_addrs.push_back(addr);
    end
  endtask

  // offer one item, wait for it to be taken, then queue its expected result
  task automatic send_access(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [7:0] wdata, input bit typed,
                             input access_result_t typed_res);
    access_result_t predicted;
    while (take_break()) begin
      access_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    access_bus.valid      <= 1'b1;
    access_bus.command    <= cmd;
    access_bus.address    <= addr;
    access_bus.write_data <= wdata;
    note_defined(cmd, addr);
    do @(posedge clk_i); while (!access_bus.ready);
    predicted = decode_access(cmd, addr, wdata);
    pending_results.push_back(typed ? typed_res : predicted);
    items_sent++;
  endtask

  // random access mix: mostly legal traffic, some refused and unmapped ones
  task automatic pick_access(output logic [1:0] cmd, output logic [15:0] addr,
                             output logic [7:0] wdata);
    int unsigned kind;
    int unsigned region;
    kind  = $urandom_range(99);
    wdata = 8'($urandom);
    if (kind < 30) begin
      cmd    = CMD_READ;
      region = $urandom_range(2);
      if (region == 0 && loaded_rom_addrs.size() != 0)
        addr = loaded_rom_addrs[$urandom_range(loaded_rom_addrs.size() - 1)];
      else if (region == 1 && written_ram_addrs.size() != 0)
        addr = written_ram_addrs[$urandom_range(written_ram_addrs.size() - 1)];
      else
        addr = PAL_FIRST + 16'($urandom_range(255));
    end else if (kind < 55) begin
      cmd = CMD_WRITE;
      if ($urandom_range(1)) addr = RAM_FIRST + 16'($urandom_range(RAM_DEPTH - 1));
      else if ($urandom_range(9) != 0) addr = PAL_FIRST + 16'($urandom_range(31));
      else addr = PAL_FIRST + 16'($urandom_range(255));
    end else if (kind < 72) begin
      cmd  = CMD_LOAD;
      addr = 16'($urandom_range(ROM_DEPTH - 1));
    end else if (kind < 80) begin
      cmd  = CMD_WRITE;
      addr = 16'($urandom_range(ROM_DEPTH - 1));
    end else begin
      cmd  = 2'($urandom);
      addr = 16'($urandom);
      // steer reads of never-defined rom / ram entries up into the gap or palette
      if (cmd == CMD_READ && addr <= RAM_LAST &&
          !((addr <= ROM_LAST) ? rom_loaded[addr[12:0]] : ram_written[addr[11:0]]))
        addr = addr | 16'h3000;
    end
  endtask

  // result receiver: random stalls, one long hold-off on request
  initial begin
    result_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        for (int unsigned n = 0; n < HOLD_CYCLES; n++) begin
          result_bus.ready <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        result_bus.ready <= !take_break();
        @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    access_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", result_bus.read_data, 8'h00);
      end else begin
        want = pending_results.pop_front();
        if (result_bus.read_data !== want.read_data)
          report_mismatch("read_data", result_bus.read_data, want.read_data);
        if (result_bus.status !== want.status)
          report_mismatch("status", 8'(result_bus.status), 8'(want.status));
      end
    end
  end

  // watchdog on cycles with no handshake on either channel
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((access_bus.valid && access_bus.ready) || (result_bus.valid && result_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("** video_bus_address_map_core: FAILED **");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    rst_ni                <= 1'b0;
    access_bus.valid      <= 1'b0;
    access_bus.command    <= CMD_READ;
    access_bus.address    <= '0;
    access_bus.write_data <= '0;
    foreach (rom_image[i]) rom_image[i] = '0;
    foreach (ram_image[i]) ram_image[i] = '0;
    foreach (bg_image[i])  bg_image[i]  = '0;
    foreach (sp_image[i])  sp_image[i]  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: extremes, every command, every error path, palette mirroring
    foreach (directed_rows[i])
      send_access(directed_rows[i].command, directed_rows[i].address,
                  directed_rows[i].write_data, directed_rows[i].typed_result,
                  directed_rows[i].result);

    // sender pause until every result is back
    access_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) hold_off_req = 1'b1;
      if (i == 250) begin
        access_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      calm_stretch = (i >= 320 && i < 420);
      pick_access(cmd, addr, wdata);
      send_access(cmd, addr, wdata, 1'b0, '0);
    end
    calm_stretch = 1'b0;
    access_bus.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("covered %0d items (%0d reads, %0d writes, %0d loads), %0d results checked",
             items_sent, n_reads, n_writes, n_loads, results_seen);
    $display("%0d error statuses, %0d palette accesses, %0d rom and %0d ram entries defined",
             n_errors, n_palette, loaded_rom_addrs.size(), written_ram_addrs.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** video_bus_address_map_core: PASSED **");
    end else begin
      $display("** video_bus_address_map_core: FAILED **");
    end
    $finish;
  end

endmodule
